@@ rtl/dynamic_point_probability_update_unit_macros.svh @@
// Assertion macros for the dynamic point probability update unit.
`ifndef DYNAMIC_POINT_PROBABILITY_UPDATE_UNIT_MACROS_SVH
`define DYNAMIC_POINT_PROBABILITY_UPDATE_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define DPU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DPU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dpu_pkg.sv @@
// Shared constants and types for the dynamic point probability update unit.
`timescale 1ns / 1ps
package dpu_pkg;

    localparam int SQRT_LAT   = 32;
    localparam int DIV_LAT    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BHA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EA    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ED    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SMR   = 3'd6;

    localparam logic [15:0] THR_RST   = 16'd58982;
    localparam logic [15:0] ALPHA_RST = 16'd52429;
    localparam logic [15:0] BETA_RST  = 16'd65208;
    localparam logic [17:0] BHA_RST   = 18'd655;
    localparam logic [15:0] EA_RST    = 16'd655;
    localparam logic [30:0] ED_RST    = 31'd655;
    localparam logic [30:0] SMR_RST   = 31'd5242880;

    typedef logic [30:0] t_q30;

    localparam t_q30 Q30_ONE = 31'h4000_0000;
    localparam t_q30 Q30_EPS = 31'd107374;
    localparam t_q30 Q30_OME = Q30_ONE - Q30_EPS;

endpackage

@@ rtl/dpu_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module dpu_sqrt (
    input  logic        i_clk,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);
    import dpu_pkg::*;

    logic [63:0] r_x   [SQRT_LAT-1];
    logic [63:0] r_res [SQRT_LAT];

    for (genvar k = 0; k < SQRT_LAT; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] x_in;
        logic [63:0] res_in;
        logic [63:0] trial;
        logic        take;

        if (k == 0) begin : g_first
            assign x_in   = i_rad;
            assign res_in = '0;
        end else begin : g_next
            assign x_in   = r_x[k-1];
            assign res_in = r_res[k-1];
        end

        assign trial = res_in + BIT;
        assign take  = (x_in >= trial);

        always_ff @(posedge i_clk) begin
            r_res[k] <= take ? ((res_in >> 1) + BIT) : (res_in >> 1);
        end

        if (k < SQRT_LAT - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_x[k] <= take ? (x_in - trial) : x_in;
            end
        end
    end

    assign o_root = r_res[SQRT_LAT-1][31:0];

endmodule

@@ rtl/dpu_div.sv @@
// Pipelined restoring divider, 64-bit dividend over 32-bit divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module dpu_div (
    input  logic        i_clk,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [31:0] o_quo,
    output logic        o_ovf
);
    import dpu_pkg::*;

    logic [63:0] r_rem [DIV_LAT-1];
    logic [31:0] r_den [DIV_LAT-1];
    logic [31:0] r_quo [DIV_LAT];
    logic        r_ovf [DIV_LAT];

    for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
        localparam int SH = DIV_LAT - 1 - k;
        logic [63:0] rem_in;
        logic [31:0] den_in;
        logic [31:0] quo_in;
        logic        ovf_in;
        logic [63:0] dsh;
        logic        take;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
            // quotient would not fit in 32 bits
            assign ovf_in = (i_num >= {i_den, 32'd0});
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
            assign ovf_in = r_ovf[k-1];
        end

        assign dsh  = {32'd0, den_in} << SH;
        assign take = (rem_in >= dsh);

        always_ff @(posedge i_clk) begin
            r_quo[k] <= take ? (quo_in | (32'd1 << SH)) : quo_in;
            r_ovf[k] <= ovf_in;
        end

        if (k < DIV_LAT - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[k] <= take ? (rem_in - dsh) : rem_in;
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];
    assign o_ovf = r_ovf[DIV_LAT-1];

endmodule

@@ rtl/dynamic_point_probability_update_unit.sv @@
// Top level of the dynamic point probability update unit.
// The path from input capture to the result strobe runs through four square roots (32 stages
// each), then three ratio dividers and the final normalizing divider (32 stages each).
// Throughput: one matched pair per cycle; busy stays low and results leave as they finish.
// Reset (i_rst_n low at a clock edge) clears every valid bit and restores the configuration registers.
`timescale 1ns / 1ps
`include "dynamic_point_probability_update_unit_macros.svh"
module dynamic_point_probability_update_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [31:0]                    i_scan_x,
    input  logic [31:0]                    i_scan_y,
    input  logic [31:0]                    i_scan_z,
    input  logic [31:0]                    i_map_x,
    input  logic [31:0]                    i_map_y,
    input  logic [31:0]                    i_map_z,
    input  logic [15:0]                    i_normal_x,
    input  logic [15:0]                    i_normal_y,
    input  logic [15:0]                    i_normal_z,
    input  logic [19:0]                    i_angle_dist_sq,
    input  logic [15:0]                    i_last_dynamic,
    input  logic                           i_matched,
    input  logic                           i_cfg_we,
    input  logic [dpu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dpu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_strobe,
    output logic [15:0]                    o_new_dynamic,
    output logic                           o_updated
);
    import dpu_pkg::*;

    function automatic logic [31:0] abs32(logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [63:0] sq32(logic [31:0] v);
        logic [31:0] a;
        a = abs32(v);
        return {32'd0, a} * {32'd0, a};
    endfunction

    function automatic logic [31:0] sat32(logic [31:0] a, logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32] != d[31]) begin
            return d[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return d[31:0];
    endfunction

    function automatic logic [61:0] mul_q(t_q30 a, t_q30 b);
        return {31'd0, a} * {31'd0, b};
    endfunction

    function automatic t_q30 clamp_q30(logic [31:0] q, logic ovf);
        return (ovf || (q > {1'b0, Q30_ONE})) ? Q30_ONE : q[30:0];
    endfunction

    typedef struct packed {
        logic [47:0] adot;
        logic [15:0] last;
        logic        matched;
    } t_side_a;

    typedef struct packed {
        logic        gfail_rng;
        logic        gfail_vis;
        logic        nm_zero;
        logic        off_lt;
        logic        dl_lt;
        logic        nm_gt;
        logic [15:0] last;
    } t_side_b;

    typedef struct packed {
        logic        gfail;
        logic        sum_zero;
        logic [15:0] last;
    } t_side_c;

    // configuration
    logic [15:0] r_thr, r_alpha, r_beta, r_ea;
    logic [17:0] r_bha;
    logic [30:0] r_ed, r_smr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RST;
            r_alpha <= ALPHA_RST;
            r_beta  <= BETA_RST;
            r_bha   <= BHA_RST;
            r_ea    <= EA_RST;
            r_ed    <= ED_RST;
            r_smr   <= SMR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THR:   r_thr   <= i_cfg_data[15:0];
                CFG_ALPHA: r_alpha <= i_cfg_data[15:0];
                CFG_BETA:  r_beta  <= i_cfg_data[15:0];
                CFG_BHA:   r_bha   <= i_cfg_data[17:0];
                CFG_EA:    r_ea    <= i_cfg_data[15:0];
                CFG_ED:    r_ed    <= i_cfg_data;
                CFG_SMR:   r_smr   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    // valid bits
    logic                r_v0, r_v1, r_v2, r_v3, r_v36, r_v37;
    logic                r_v70, r_v71, r_v72, r_v73, r_v74, r_v75, r_v76;
    logic [SQRT_LAT-1:0] r_va_line;
    logic [DIV_LAT-1:0]  r_vb_line, r_vc_line;
    logic                r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_va_line <= '0;
            r_v36     <= 1'b0;
            r_v37     <= 1'b0;
            r_vb_line <= '0;
            r_v70     <= 1'b0;
            r_v71     <= 1'b0;
            r_v72     <= 1'b0;
            r_v73     <= 1'b0;
            r_v74     <= 1'b0;
            r_v75     <= 1'b0;
            r_v76     <= 1'b0;
            r_vc_line <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_v0      <= start && !busy;
            r_v1      <= r_v0;
            r_v2      <= r_v1;
            r_v3      <= r_v2;
            r_va_line <= {r_va_line[SQRT_LAT-2:0], r_v3};
            r_v36     <= r_va_line[SQRT_LAT-1];
            r_v37     <= r_v36;
            r_vb_line <= {r_vb_line[DIV_LAT-2:0], r_v37};
            r_v70     <= r_vb_line[DIV_LAT-1];
            r_v71     <= r_v70;
            r_v72     <= r_v71;
            r_v73     <= r_v72;
            r_v74     <= r_v73;
            r_v75     <= r_v74;
            r_v76     <= r_v75;
            r_vc_line <= {r_vc_line[DIV_LAT-2:0], r_v76};
            r_strobe  <= r_vc_line[DIV_LAT-1];
        end
    end

    // stage 0: input capture
    logic [31:0]        r_sx0, r_sy0, r_sz0, r_mx0, r_my0, r_mz0;
    logic signed [15:0] r_nx0, r_ny0, r_nz0;
    logic [19:0]        r_ang0;
    logic [15:0]        r_last0;
    logic               r_match0;

    always_ff @(posedge i_clk) begin
        r_sx0    <= i_scan_x;
        r_sy0    <= i_scan_y;
        r_sz0    <= i_scan_z;
        r_mx0    <= i_map_x;
        r_my0    <= i_map_y;
        r_mz0    <= i_map_z;
        r_nx0    <= i_normal_x;
        r_ny0    <= i_normal_y;
        r_nz0    <= i_normal_z;
        r_ang0   <= i_angle_dist_sq;
        r_last0  <= i_last_dynamic;
        r_match0 <= i_matched;
    end

    // stage 1: differences, normal dot partial products
    logic [31:0]        r_sx1, r_sy1, r_sz1, r_mx1, r_my1, r_mz1, r_dx1, r_dy1, r_dz1;
    logic signed [47:0] r_px1, r_py1, r_pz1;
    logic [19:0]        r_ang1;
    logic [15:0]        r_last1;
    logic               r_match1;

    always_ff @(posedge i_clk) begin
        r_sx1    <= r_sx0;
        r_sy1    <= r_sy0;
        r_sz1    <= r_sz0;
        r_mx1    <= r_mx0;
        r_my1    <= r_my0;
        r_mz1    <= r_mz0;
        r_dx1    <= sat32(r_sx0, r_mx0);
        r_dy1    <= sat32(r_sy0, r_my0);
        r_dz1    <= sat32(r_sz0, r_mz0);
        r_px1    <= r_nx0 * $signed(r_mx0);
        r_py1    <= r_ny0 * $signed(r_my0);
        r_pz1    <= r_nz0 * $signed(r_mz0);
        r_ang1   <= r_ang0;
        r_last1  <= r_last0;
        r_match1 <= r_match0;
    end

    // stage 2: squares, dot sum
    logic [63:0]        r_qsx2, r_qsy2, r_qsz2, r_qmx2, r_qmy2, r_qmz2, r_qdx2, r_qdy2, r_qdz2;
    logic signed [49:0] r_dot2;
    logic [19:0]        r_ang2;
    logic [15:0]        r_last2;
    logic               r_match2;

    always_ff @(posedge i_clk) begin
        r_qsx2   <= sq32(r_sx1);
        r_qsy2   <= sq32(r_sy1);
        r_qsz2   <= sq32(r_sz1);
        r_qmx2   <= sq32(r_mx1);
        r_qmy2   <= sq32(r_my1);
        r_qmz2   <= sq32(r_mz1);
        r_qdx2   <= sq32(r_dx1);
        r_qdy2   <= sq32(r_dy1);
        r_qdz2   <= sq32(r_dz1);
        r_dot2   <= {{2{r_px1[47]}}, r_px1} + {{2{r_py1[47]}}, r_py1}
                  + {{2{r_pz1[47]}}, r_pz1};
        r_ang2   <= r_ang1;
        r_last2  <= r_last1;
        r_match2 <= r_match1;
    end

    // stage 3: radicands
    logic [63:0] r_rad_s3, r_rad_m3, r_rad_d3, r_rad_a3;
    logic [49:0] w_dot_abs;
    logic [47:0] r_adot3;
    logic [15:0] r_last3;
    logic        r_match3;

    assign w_dot_abs = r_dot2[49] ? (~r_dot2 + 50'd1) : r_dot2;

    always_ff @(posedge i_clk) begin
        r_rad_s3 <= r_qsx2 + r_qsy2 + r_qsz2;
        r_rad_m3 <= r_qmx2 + r_qmy2 + r_qmz2;
        r_rad_d3 <= r_qdx2 + r_qdy2 + r_qdz2;
        r_rad_a3 <= {28'd0, r_ang2, 16'd0};
        r_adot3  <= w_dot_abs[47:0];
        r_last3  <= r_last2;
        r_match3 <= r_match2;
    end

    logic [31:0] w_ns, w_nm, w_nd, w_na;

    dpu_sqrt u_sqrt_s (.i_clk(i_clk), .i_rad(r_rad_s3), .o_root(w_ns));
    dpu_sqrt u_sqrt_m (.i_clk(i_clk), .i_rad(r_rad_m3), .o_root(w_nm));
    dpu_sqrt u_sqrt_d (.i_clk(i_clk), .i_rad(r_rad_d3), .o_root(w_nd));
    dpu_sqrt u_sqrt_a (.i_clk(i_clk), .i_rad(r_rad_a3), .o_root(w_na));

    t_side_a r_sa_line [SQRT_LAT];

    always_ff @(posedge i_clk) begin
        r_sa_line[0] <= '{adot: r_adot3, last: r_last3, matched: r_match3};
        for (int i = 1; i < SQRT_LAT; i++) begin
            r_sa_line[i] <= r_sa_line[i-1];
        end
    end

    // stage 36: range gate, tolerance product, distance offset
    t_side_a     w_sa;
    logic [31:0] r_ns36, r_nm36, r_off36;
    logic [17:0] r_sa36;
    logic [47:0] r_dprod36, r_adot36;
    logic [15:0] r_last36;
    logic        r_rgfail36, r_dllt36, r_nmgt36;

    assign w_sa = r_sa_line[SQRT_LAT-1];

    always_ff @(posedge i_clk) begin
        r_ns36     <= w_ns;
        r_nm36     <= w_nm;
        r_sa36     <= w_na[17:0];
        r_dprod36  <= {32'd0, r_ea} * {16'd0, w_ns};
        r_rgfail36 <= !w_sa.matched || (w_nm >= {1'b0, r_smr});
        r_dllt36   <= (w_nd < {1'b0, r_ed});
        r_off36    <= w_nd - {1'b0, r_ed};
        r_nmgt36   <= (w_nm > w_ns);
        r_adot36   <= w_sa.adot;
        r_last36   <= w_sa.last;
    end

    // stage 37: visibility gate, divider operands
    logic [31:0] w_dmax;
    logic [33:0] w_vis_sum;
    logic        w_offlt;
    logic [63:0] r_cdiv_num, r_adiv_num, r_ddiv_num;
    logic [31:0] r_cdiv_den, r_adiv_den, r_ddiv_den;
    t_side_b     r_sb37;

    assign w_dmax    = r_dprod36[47:16];
    assign w_vis_sum = {2'b0, r_ns36} + {3'b0, r_ed} + {2'b0, w_dmax};
    assign w_offlt   = !r_dllt36 && (r_off36 < w_dmax);

    always_ff @(posedge i_clk) begin
        r_cdiv_num <= {1'b0, r_adot36, 15'd0};
        r_cdiv_den <= r_nm36;
        r_adiv_num <= {16'd0, r_sa36, 30'd0};
        r_adiv_den <= {13'd0, r_bha, 1'b0};
        r_ddiv_num <= w_offlt ? {2'd0, r_off36, 30'd0} : '0;
        r_ddiv_den <= w_dmax;
        r_sb37     <= '{gfail_rng: r_rgfail36,
                        gfail_vis: (w_vis_sum < {2'b0, r_nm36}),
                        nm_zero:   (r_nm36 == '0),
                        off_lt:    w_offlt,
                        dl_lt:     r_dllt36,
                        nm_gt:     r_nmgt36,
                        last:      r_last36};
    end

    logic [31:0] w_cq, w_aq, w_dq;
    logic        w_covf, w_aovf;

    dpu_div u_div_cos (.i_clk(i_clk), .i_num(r_cdiv_num), .i_den(r_cdiv_den),
                       .o_quo(w_cq), .o_ovf(w_covf));
    dpu_div u_div_ang (.i_clk(i_clk), .i_num(r_adiv_num), .i_den(r_adiv_den),
                       .o_quo(w_aq), .o_ovf(w_aovf));
    // only taken when offset < dmax, so the quotient stays below one
    dpu_div u_div_dst (.i_clk(i_clk), .i_num(r_ddiv_num), .i_den(r_ddiv_den),
                       .o_quo(w_dq), .o_ovf());

    t_side_b r_sb_line [DIV_LAT];

    always_ff @(posedge i_clk) begin
        r_sb_line[0] <= r_sb37;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_sb_line[i] <= r_sb_line[i-1];
        end
    end

    // stage 70: clamp ratios, weight and transition products
    t_side_b     w_sb;
    t_q30        w_cosv, w_ra, w_rd, w_l, w_a, w_b;
    logic [61:0] r_p_wv70, r_p_wd1_70, r_p_wd2_70, r_p_wp2_70;
    logic [61:0] r_p_td1_70, r_p_td2_70, r_p_ts1_70, r_p_ts2_70;
    logic        r_gfail70, r_offlt70, r_dllt70, r_nmgt70;
    logic [15:0] r_last70;

    assign w_sb   = r_sb_line[DIV_LAT-1];
    assign w_cosv = w_sb.nm_zero ? '0 : clamp_q30(w_cq, w_covf);
    assign w_ra   = (r_bha == '0) ? Q30_ONE : clamp_q30(w_aq, w_aovf);
    assign w_rd   = w_sb.off_lt ? w_dq[30:0] : '0;
    assign w_l    = {1'b0, w_sb.last, 14'd0};
    assign w_a    = {1'b0, r_alpha, 14'd0};
    assign w_b    = {1'b0, r_beta, 14'd0};

    always_ff @(posedge i_clk) begin
        r_p_wv70   <= mul_q(Q30_OME, w_cosv);
        r_p_wd1_70 <= mul_q(Q30_OME, Q30_ONE - w_ra);
        r_p_wd2_70 <= mul_q(Q30_OME, w_rd);
        r_p_wp2_70 <= mul_q(Q30_OME, Q30_ONE - w_rd);
        r_p_td1_70 <= mul_q(Q30_ONE - w_a, Q30_ONE - w_l);
        r_p_td2_70 <= mul_q(w_b, w_l);
        r_p_ts1_70 <= mul_q(w_a, Q30_ONE - w_l);
        r_p_ts2_70 <= mul_q(Q30_ONE - w_b, w_l);
        r_gfail70  <= w_sb.gfail_rng || w_sb.gfail_vis;
        r_offlt70  <= w_sb.off_lt;
        r_dllt70   <= w_sb.dl_lt;
        r_nmgt70   <= w_sb.nm_gt;
        r_last70   <= w_sb.last;
    end

    // stage 71: weights and transition terms
    logic [62:0] w_td_sum, w_ts_sum;
    t_q30        r_wv71, r_wd1_71, r_wd2_71, r_wp2_71, r_td71, r_ts71;
    logic        r_gfail71;
    logic [15:0] r_last71;

    assign w_td_sum = {1'b0, r_p_td1_70} + {1'b0, r_p_td2_70};
    assign w_ts_sum = {1'b0, r_p_ts1_70} + {1'b0, r_p_ts2_70};

    always_ff @(posedge i_clk) begin
        r_wv71   <= Q30_EPS + r_p_wv70[60:30];
        r_wd1_71 <= Q30_EPS + r_p_wd1_70[60:30];
        if (r_dllt70 || r_nmgt70) begin
            r_wd2_71 <= Q30_EPS;
        end else if (r_offlt70) begin
            r_wd2_71 <= Q30_EPS + r_p_wd2_70[60:30];
        end else begin
            r_wd2_71 <= Q30_ONE;
        end
        if (r_dllt70) begin
            r_wp2_71 <= Q30_ONE;
        end else if (r_offlt70) begin
            r_wp2_71 <= Q30_EPS + r_p_wp2_70[60:30];
        end else begin
            r_wp2_71 <= Q30_EPS;
        end
        r_td71    <= w_td_sum[60:30];
        r_ts71    <= w_ts_sum[60:30];
        r_gfail71 <= r_gfail70;
        r_last71  <= r_last70;
    end

    // stage 72: observation weight product
    logic [61:0] r_p_c2_72;
    t_q30        r_wd2_72, r_wp2_72, r_td72, r_ts72;
    logic        r_gfail72;
    logic [15:0] r_last72;

    always_ff @(posedge i_clk) begin
        r_p_c2_72 <= mul_q(r_wv71, r_wd1_71);
        r_wd2_72  <= r_wd2_71;
        r_wp2_72  <= r_wp2_71;
        r_td72    <= r_td71;
        r_ts72    <= r_ts71;
        r_gfail72 <= r_gfail71;
        r_last72  <= r_last71;
    end

    // stage 73: split into kept and observed parts
    t_q30        w_c2, w_c1, w_l73;
    logic [61:0] r_p_c2wd2_73, r_p_c2wp2_73, r_p_c1l_73, r_p_c1nl_73;
    t_q30        r_td73, r_ts73;
    logic        r_gfail73;
    logic [15:0] r_last73;

    assign w_c2  = r_p_c2_72[60:30];
    assign w_c1  = Q30_ONE - w_c2;
    assign w_l73 = {1'b0, r_last72, 14'd0};

    always_ff @(posedge i_clk) begin
        r_p_c2wd2_73 <= mul_q(w_c2, r_wd2_72);
        r_p_c2wp2_73 <= mul_q(w_c2, r_wp2_72);
        r_p_c1l_73   <= mul_q(w_c1, w_l73);
        r_p_c1nl_73  <= mul_q(w_c1, Q30_ONE - w_l73);
        r_td73       <= r_td72;
        r_ts73       <= r_ts72;
        r_gfail73    <= r_gfail72;
        r_last73     <= r_last72;
    end

    // stage 74: observed terms times transition
    logic [61:0] r_p_u74, r_p_w74;
    t_q30        r_a74, r_b74;
    logic        r_gfail74;
    logic [15:0] r_last74;

    always_ff @(posedge i_clk) begin
        r_p_u74   <= mul_q(r_p_c2wd2_73[60:30], r_td73);
        r_p_w74   <= mul_q(r_p_c2wp2_73[60:30], r_ts73);
        r_a74     <= r_p_c1l_73[60:30];
        r_b74     <= r_p_c1nl_73[60:30];
        r_gfail74 <= r_gfail73;
        r_last74  <= r_last73;
    end

    // stage 75: dynamic and static beliefs, latch at or above threshold
    logic [31:0] r_pd75, r_ps75;
    logic        r_gfail75;
    logic [15:0] r_last75;

    always_ff @(posedge i_clk) begin
        if (r_last74 >= r_thr) begin
            r_pd75 <= {1'b0, Q30_OME};
            r_ps75 <= {1'b0, Q30_EPS};
        end else begin
            r_pd75 <= {1'b0, r_a74} + {1'b0, r_p_u74[60:30]};
            r_ps75 <= {1'b0, r_b74} + {1'b0, r_p_w74[60:30]};
        end
        r_gfail75 <= r_gfail74;
        r_last75  <= r_last74;
    end

    // stage 76: normalizer operands, rounded half up
    logic [32:0] w_sum;
    logic [63:0] r_fdiv_num;
    logic [31:0] r_fdiv_den;
    t_side_c     r_sc76;

    assign w_sum = {1'b0, r_pd75} + {1'b0, r_ps75};

    always_ff @(posedge i_clk) begin
        r_fdiv_num <= {16'd0, r_pd75, 16'd0} + {32'd0, w_sum[32:1]};
        r_fdiv_den <= w_sum[31:0];
        r_sc76     <= '{gfail: r_gfail75, sum_zero: (w_sum == '0), last: r_last75};
    end

    logic [31:0] w_fq;
    logic        w_fovf;

    dpu_div u_div_fin (.i_clk(i_clk), .i_num(r_fdiv_num), .i_den(r_fdiv_den),
                       .o_quo(w_fq), .o_ovf(w_fovf));

    t_side_c r_sc_line [DIV_LAT];

    always_ff @(posedge i_clk) begin
        r_sc_line[0] <= r_sc76;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_sc_line[i] <= r_sc_line[i-1];
        end
    end

    // output register
    t_side_c     w_sc;
    logic [15:0] w_res;
    logic [15:0] r_new;
    logic        r_upd;

    assign w_sc  = r_sc_line[DIV_LAT-1];
    assign w_res = (w_fovf || (w_fq > 32'd65535)) ? 16'hFFFF : w_fq[15:0];

    always_ff @(posedge i_clk) begin
        r_new <= (w_sc.gfail || w_sc.sum_zero) ? w_sc.last : w_res;
        r_upd <= r_vc_line[DIV_LAT-1] && !w_sc.gfail;
    end

    assign o_strobe      = r_strobe;
    assign o_new_dynamic = r_new;
    assign o_updated     = r_upd;

    `DPU_ASSERT_IMP(a_upd_has_strobe, o_updated, o_strobe, "updated flag without a result strobe")
    `DPU_ASSERT_IMP(a_tail_reaches_out, r_v76, ##33 o_strobe, "belief stage item lost before output")
    `DPU_ASSERT_NXT(a_gated_echo, r_vc_line[DIV_LAT-1] && w_sc.gfail,
        !o_updated && (o_new_dynamic == $past(w_sc.last)), "gated item not echoed unchanged")

endmodule

@@ bench/dynamic_point_probability_update_unit_test.sv @@
// Testbench for the dynamic point probability update unit: directed and random matched pairs.
`timescale 1ns / 1ps
module dynamic_point_probability_update_unit_test;
    import dpu_pkg::*;

    typedef struct {
        logic signed [31:0] sx, sy, sz, mx, my, mz;
        logic signed [15:0] nx, ny, nz;
        logic [19:0]        ang;
        logic [15:0]        last;
        logic               matched;
    } t_pair;

    typedef struct {
        logic [15:0] prob;
        logic        upd;
    } t_prob;

    localparam longint unsigned ONE = 64'd1 << 30;
    localparam longint unsigned EPS = 64'd107374;
    localparam int DRAIN_CYCLES = 120;
    localparam int M1 = 65536;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [31:0] i_scan_x, i_scan_y, i_scan_z, i_map_x, i_map_y, i_map_z;
    logic [15:0] i_normal_x, i_normal_y, i_normal_z;
    logic [19:0] i_angle_dist_sq;
    logic [15:0] i_last_dynamic;
    logic i_matched;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic o_strobe;
    logic [15:0] o_new_dynamic;
    logic o_updated;

    // register copies for the predictor
    longint unsigned thr_reg, alpha_reg, beta_reg, bha_reg, ea_reg, ed_reg, smr_reg;

    t_prob pending_q[$];
    int fail_count;
    int idle_pct;

    dynamic_point_probability_update_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_scan_x(i_scan_x), .i_scan_y(i_scan_y), .i_scan_z(i_scan_z),
        .i_map_x(i_map_x), .i_map_y(i_map_y), .i_map_z(i_map_z),
        .i_normal_x(i_normal_x), .i_normal_y(i_normal_y), .i_normal_z(i_normal_z),
        .i_angle_dist_sq(i_angle_dist_sq), .i_last_dynamic(i_last_dynamic),
        .i_matched(i_matched), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_strobe(o_strobe), .o_new_dynamic(o_new_dynamic),
        .o_updated(o_updated)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag_sq(longint v);
        longint unsigned a;
        a = (v < 0) ? 64'd0 - longint'(v) : longint'(v);
        return a * a;
    endfunction

    function automatic longint unsigned length3(longint x, longint y, longint z);
        return int_sqrt(mag_sq(x) + mag_sq(y) + mag_sq(z));
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    // new dynamic probability of one matched pair under the current registers
    function automatic t_prob predict_probability(t_pair p);
        t_prob r;
        longint sx, sy, sz, mx, my, mz, dot, offset;
        longint unsigned ns, nm, delta, dmax, adot, cosv, ratio, wv, wd1, wd2, wp2;
        longint unsigned c1, c2, lq, aq, bq, td, ts, pd, ps, total, q;
        sx = p.sx; sy = p.sy; sz = p.sz;
        mx = p.mx; my = p.my; mz = p.mz;
        r.prob = p.last;
        r.upd = 1'b0;
        ns = length3(sx, sy, sz);
        nm = length3(mx, my, mz);
        if (!p.matched || nm >= smr_reg) return r;
        delta = length3(clip32(sx - mx), clip32(sy - my), clip32(sz - mz));
        dmax = (ea_reg * ns) >> 16;
        if (ns + ed_reg + dmax < nm) return r;

        dot = longint'(p.nx) * mx + longint'(p.ny) * my + longint'(p.nz) * mz;
        adot = (dot < 0) ? 64'd0 - dot : dot;
        cosv = (nm == 0) ? 0 : (adot << 15) / nm;
        if (cosv > ONE) cosv = ONE;
        wv = EPS + qmul(ONE - EPS, cosv);

        if (bha_reg == 0) begin
            ratio = ONE;
        end else begin
            ratio = (int_sqrt(longint'(p.ang) << 16) << 30) / (2 * bha_reg);
            if (ratio > ONE) ratio = ONE;
        end
        wd1 = EPS + qmul(ONE - EPS, ONE - ratio);

        offset = longint'(delta) - longint'(ed_reg);
        ratio = 0;
        if (offset >= 0 && longint'(offset) < dmax) ratio = (longint'(offset) << 30) / dmax;
        if (delta < ed_reg || nm > ns) wd2 = EPS;
        else if (longint'(offset) < dmax) wd2 = EPS + qmul(ONE - EPS, ratio);
        else wd2 = ONE;
        if (delta < ed_reg) wp2 = ONE;
        else if (longint'(offset) < dmax) wp2 = EPS + qmul(ONE - EPS, ONE - ratio);
        else wp2 = EPS;

        if (p.last < thr_reg) begin
            c2 = qmul(wv, wd1);
            c1 = ONE - c2;
            lq = longint'(p.last) << 14;
            aq = alpha_reg << 14;
            bq = beta_reg << 14;
            td = ((ONE - aq) * (ONE - lq) + bq * lq) >> 30;
            ts = (aq * (ONE - lq) + (ONE - bq) * lq) >> 30;
            pd = qmul(c1, lq) + qmul(qmul(c2, wd2), td);
            ps = qmul(c1, ONE - lq) + qmul(qmul(c2, wp2), ts);
        end else begin
            pd = ONE - EPS;
            ps = EPS;
        end
        r.upd = 1'b1;
        total = pd + ps;
        if (total == 0) return r;
        q = ((pd << 16) + (total >> 1)) / total;
        if (q > 65535) q = 65535;
        r.prob = q[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_prob want;
        if (i_rst_n && o_strobe) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", o_new_dynamic, 16'd0);
            end else begin
                want = pending_q.pop_front();
                if (o_new_dynamic !== want.prob)
                    report_mismatch("new_dynamic", o_new_dynamic, want.prob);
                if (o_updated !== want.upd)
                    report_mismatch("updated", {15'd0, o_updated}, {15'd0, want.upd});
            end
        end
    end

    // one transfer; optional sender gap before it
    task automatic send_pair(t_pair p);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_scan_x <= p.sx; i_scan_y <= p.sy; i_scan_z <= p.sz;
        i_map_x <= p.mx; i_map_y <= p.my; i_map_z <= p.mz;
        i_normal_x <= p.nx; i_normal_y <= p.ny; i_normal_z <= p.nz;
        i_angle_dist_sq <= p.ang;
        i_last_dynamic <= p.last;
        i_matched <= p.matched;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_q.push_back(predict_probability(p));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val[30:0];
        @(posedge i_clk);
        case (idx)
            CFG_THR:   thr_reg = val & 64'hFFFF;
            CFG_ALPHA: alpha_reg = val & 64'hFFFF;
            CFG_BETA:  beta_reg = val & 64'hFFFF;
            CFG_BHA:   bha_reg = val & 64'h3FFFF;
            CFG_EA:    ea_reg = val & 64'hFFFF;
            CFG_ED:    ed_reg = val & 64'h7FFFFFFF;
            CFG_SMR:   smr_reg = val & 64'h7FFFFFFF;
            default: ;
        endcase
    endtask

    task automatic set_all(longint unsigned thr, longint unsigned al, longint unsigned be,
                           longint unsigned bha, longint unsigned ea, longint unsigned ed,
                           longint unsigned smr);
        drain();
        write_reg(CFG_THR, thr);
        write_reg(CFG_ALPHA, al);
        write_reg(CFG_BETA, be);
        write_reg(CFG_BHA, bha);
        write_reg(CFG_EA, ea);
        write_reg(CFG_ED, ed);
        write_reg(CFG_SMR, smr);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_pair make_pair(int sx, int sy, int sz, int mx, int my, int mz,
                                        int nx, int ny, int nz, int ang, int last, bit m);
        t_pair p;
        p.sx = sx; p.sy = sy; p.sz = sz;
        p.mx = mx; p.my = my; p.mz = mz;
        p.nx = 16'(nx); p.ny = 16'(ny); p.nz = 16'(nz);
        p.ang = 20'(ang); p.last = 16'(last); p.matched = m;
        return p;
    endfunction

    // mostly plausible geometry: scan point close to a map point within range
    function automatic t_pair random_pair();
        t_pair p;
        int span, dj;
        p.nx = 16'($urandom); p.ny = 16'($urandom); p.nz = 16'($urandom);
        p.last = 16'($urandom);
        p.matched = ($urandom_range(9) != 0);
        if ($urandom_range(99) < 15) begin
            p.sx = $urandom; p.sy = $urandom; p.sz = $urandom;
            p.mx = $urandom; p.my = $urandom; p.mz = $urandom;
            p.ang = 20'($urandom);
            return p;
        end
        span = 30 * M1;
        p.mx = int'($urandom_range(0, 2 * span)) - span;
        p.my = int'($urandom_range(0, 2 * span)) - span;
        p.mz = int'($urandom_range(0, span / 4)) - span / 8;
        case ($urandom_range(2))
            0: dj = 512;
            1: dj = 8192;
            default: dj = M1;
        endcase
        p.sx = p.mx + int'($urandom_range(0, 2 * dj)) - dj;
        p.sy = p.my + int'($urandom_range(0, 2 * dj)) - dj;
        p.sz = p.mz + int'($urandom_range(0, 2 * dj)) - dj;
        p.ang = 20'(($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 40));
        return p;
    endfunction

    task automatic run_random(int n, int pct);
        idle_pct = pct;
        repeat (n) send_pair(random_pair());
        idle_pct = 0;
    endtask

    task automatic test_directed_defaults();
        send_pair(make_pair(M1, 0, 0, M1, 0, 0, 0, 0, 0, 0, 1234, 1'b0));
        send_pair(make_pair(100 * M1, 0, 0, 100 * M1, 0, 0, 0, 0, 32767, 0, 500, 1'b1));
        send_pair(make_pair(M1, 0, 0, 50 * M1, 0, 0, 32767, 0, 0, 5, 500, 1'b1));
        send_pair(make_pair(5 * M1, 0, 0, 5 * M1, 10, 0, 0, 32767, 0, 2, 65535, 1'b1));
        send_pair(make_pair(M1, M1, 0, 0, 0, 0, 100, -100, 5, 3, 30000, 1'b1));
        send_pair(make_pair(8 * M1, 0, 0, 8 * M1, 0, 0, -32768, 0, 0, 0, 0, 1'b1));
        send_pair(make_pair(8 * M1 + 600, 0, 0, 8 * M1, 0, 0, -32768, 0, 0, 0, 65535, 1'b1));
        send_pair(make_pair(8 * M1 + 3000, 0, 0, 8 * M1, 0, 0, 0, 0, 32767, 0, 0, 1'b1));
        send_pair(make_pair(3 * M1, 2 * M1, M1, 3 * M1 - 200, 2 * M1, M1, 16000, 16000, 0,
                            20'hFFFFF, 20000, 1'b1));
        send_pair(make_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -1, -1, -1,
                            -32768, -32768, -32768, 20'hFFFFF, 65535, 1'b1));
        send_pair(make_pair(32'h80000000, 32'h80000000, 32'h80000000, 1, 1, 1,
                            32767, 32767, 32767, 0, 0, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, -1, 20'hFFFFF, 65535, 1'b1));
        send_pair(make_pair(10 * M1, 0, 0, 10 * M1 - 100, 0, 0, 0, 32767, 0, 1, 58981, 1'b1));
        send_pair(make_pair(10 * M1, 0, 0, 10 * M1 - 100, 0, 0, 0, 32767, 0, 1, 58982, 1'b1));
    endtask

    task automatic test_zero_beam_angle();
        set_all(30000, 40000, 60000, 0, 1000, 2000, 200 * M1);
        send_pair(make_pair(4 * M1, M1, 0, 4 * M1 - 900, M1, 0, 20000, 3000, 0, 0, 100, 1'b1));
        send_pair(make_pair(4 * M1, M1, 0, 4 * M1, M1, 0, -32768, 0, 0, 7, 100, 1'b1));
        run_random(100, 0);
    endtask

    task automatic test_max_registers();
        set_all(65535, 65535, 65535, 205887, 65535, 31'h7FFFFFFF, 31'h7FFFFFFF);
        send_pair(make_pair(32'h7FFFFFFF, 0, 0, -1, 0, 0, 0, 0, 32767, 9, 65534, 1'b1));
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        run_random(200, 60);
    endtask

    task automatic test_min_registers();
        set_all(0, 0, 0, 0, 0, 0, 0);
        run_random(50, 29);
        set_all(65535, 0, 0, 1, 0, 0, 31'h7FFFFFFF);
        send_pair(make_pair(8 * M1, 0, 0, 8 * M1, 0, 0, -32768, 0, 0, 0, 0, 1'b1));
        run_random(100, 29);
    endtask

    task automatic test_random_settings();
        repeat (2) begin
            set_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 205887),
                    $urandom_range(0, 65535), $urandom_range(0, 20 * M1),
                    $urandom_range(0, 31'h7FFFFFFF));
            run_random(150, $urandom_range(0, 1) ? 60 : 0);
        end
    endtask

    initial begin
        fail_count = 0;
        idle_pct = 0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_scan_x <= '0; i_scan_y <= '0; i_scan_z <= '0;
        i_map_x <= '0; i_map_y <= '0; i_map_z <= '0;
        i_normal_x <= '0; i_normal_y <= '0; i_normal_z <= '0;
        i_angle_dist_sq <= '0;
        i_last_dynamic <= '0;
        i_matched <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        thr_reg = THR_RST; alpha_reg = ALPHA_RST; beta_reg = BETA_RST;
        bha_reg = BHA_RST; ea_reg = EA_RST; ed_reg = ED_RST; smr_reg = SMR_RST;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        run_random(250, 0);
        run_random(150, 60);
        run_random(150, 29);
        test_zero_beam_angle();
        test_max_registers();
        test_min_registers();
        test_random_settings();
        set_all(THR_RST, ALPHA_RST, BETA_RST, BHA_RST, EA_RST, ED_RST, SMR_RST);
        run_random(50, 29);

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
